// File: src/tlsc_pkg.sv
`default_nettype none

package tlsc_pkg;

   // Width of the per-line byte counter and of the column indexes.
   localparam int COUNT_WIDTH = 20;

   localparam int LEN_W       = 16;
   localparam int LINE_W      = 32;
   localparam int COL_W       = 20;
   localparam int KIND_W      = 2;
   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 6;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [COL_W-1:0]       COL_MAX   = '1;
   localparam logic [LINE_W-1:0]      LINE_MAX  = '1;

   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_SP  = 8'h20;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END  = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_LONG  = 2'd0,
      KIND_TAB   = 2'd1,
      KIND_TRAIL = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      REG_MAX_LEN  = 2'd0,
      REG_TAB_EN   = 2'd1,
      REG_TRAIL_EN = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [LEN_W-1:0] max_line_length;
      logic             tab_check_enable;
      logic             trailing_check_enable;
   } cfg_type;

   typedef struct packed {
      logic [KIND_W-1:0] violation_kind;
      logic [LINE_W-1:0] line_number;
      logic [COL_W-1:0]  column_number;
      logic              last_of_line;
   } result_type;

   typedef struct packed {
      logic [1:0]                   count;
      result_type [MAX_RESULTS-1:0] items;
   } burst_type;

   // One-based column from a zero-based index, saturating at the column maximum.
   function automatic logic [COL_W-1:0] to_column(input logic [COUNT_WIDTH-1:0] idx);
      logic [32:0] sum;
      sum = 33'(idx) + 33'd1;
      if (sum > 33'(COL_MAX)) begin
         return COL_MAX;
      end
      return sum[COL_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: src/tlsc_if.sv
`default_nettype none

interface tlsc_req_if;
   import tlsc_pkg::*;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] text_byte;

   modport source (output valid, output cmd, output text_byte, input ready);
   modport sink   (input valid, input cmd, input text_byte, output ready);
endinterface

interface tlsc_rsp_if;
   import tlsc_pkg::*;
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] violation_kind;
   logic [LINE_W-1:0] line_number;
   logic [COL_W-1:0]  column_number;
   logic              last_of_line;

   modport source (output valid, output violation_kind, output line_number,
                   output column_number, output last_of_line, input ready);
   modport sink   (input valid, input violation_kind, input line_number,
                   input column_number, input last_of_line, output ready);
endinterface

`default_nettype wire

// File: src/tlsc_csr.sv
`default_nettype none

module tlsc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tlsc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [tlsc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [tlsc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready,
   output tlsc_pkg::cfg_type               cfg
);
   import tlsc_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       write_en;
   logic [1:0] reg_sel;

   // Registers sit on word boundaries, so the low address bits are ignored.
   assign reg_sel  = paddr[3:2];
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_sel)
            REG_MAX_LEN:  cfg_in.max_line_length       = pwdata[LEN_W-1:0];
            REG_TAB_EN:   cfg_in.tab_check_enable      = pwdata[0];
            REG_TRAIL_EN: cfg_in.trailing_check_enable = pwdata[0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_MAX_LEN:  prdata = CSR_DATA_W'(cfg_ff.max_line_length);
         REG_TAB_EN:   prdata = CSR_DATA_W'(cfg_ff.tab_check_enable);
         REG_TRAIL_EN: prdata = CSR_DATA_W'(cfg_ff.trailing_check_enable);
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: src/tlsc_line.sv
`default_nettype none

module tlsc_line (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                cmd,
   input  logic [7:0]          text_byte,
   input  tlsc_pkg::cfg_type   cfg,
   output tlsc_pkg::burst_type burst
);
   import tlsc_pkg::*;

   logic [LINE_W-1:0]      line_count_ff, line_count_in;
   logic [COUNT_WIDTH-1:0] byte_count_ff, byte_count_in;
   logic [7:0]             last_byte_ff, last_byte_in;
   logic [7:0]             previous_byte_ff, previous_byte_in;
   logic [COUNT_WIDTH-1:0] run_start_ff, run_start_in;
   logic [COUNT_WIDTH-1:0] run_start_prev_ff, run_start_prev_in;
   logic [COUNT_WIDTH-1:0] first_tab_ff, first_tab_in;
   logic                   tab_seen_ff, tab_seen_in;

   logic [COUNT_WIDTH-1:0] len;
   logic [7:0]             lastc;
   logic [COUNT_WIDTH-1:0] run;
   logic                   flag_long;
   logic                   flag_tab;
   logic                   flag_trail;
   logic [COUNT_WIDTH-1:0] next_count;

   // Line checks, with one trailing CR dropped.
   always_comb begin
      len   = byte_count_ff;
      lastc = last_byte_ff;
      run   = run_start_ff;
      if (byte_count_ff != '0 && last_byte_ff == CH_CR) begin
         len   = byte_count_ff - COUNT_WIDTH'(1);
         lastc = previous_byte_ff;
         run   = run_start_prev_ff;
      end
      flag_long  = (cfg.max_line_length != '0) &&
                   (len > COUNT_WIDTH'(cfg.max_line_length));
      flag_tab   = cfg.tab_check_enable && tab_seen_ff;
      flag_trail = cfg.trailing_check_enable && (len != '0) &&
                   (lastc == CH_SP || (lastc == CH_TAB && !flag_tab));
   end

   // Pack the violations that fired into consecutive slots, in report order.
   always_comb begin
      logic [1:0] n;
      result_type item;
      n           = 2'd0;
      burst.items = '0;
      item        = '0;
      item.line_number = line_count_ff;
      if (flag_long) begin
         item.violation_kind = KIND_LONG;
         item.column_number  = to_column(COUNT_WIDTH'(cfg.max_line_length));
         burst.items[n]      = item;
         n                   = n + 2'd1;
      end
      if (flag_tab) begin
         item.violation_kind = KIND_TAB;
         item.column_number  = to_column(first_tab_ff);
         burst.items[n]      = item;
         n                   = n + 2'd1;
      end
      if (flag_trail) begin
         item.violation_kind = KIND_TRAIL;
         item.column_number  = to_column(run);
         burst.items[n]      = item;
         n                   = n + 2'd1;
      end
      for (int k = 0; k < MAX_RESULTS; k++) begin
         burst.items[k].last_of_line = (2'(k) + 2'd1 == n);
      end
      // Only a line close reports anything.
      burst.count = (cmd == CMD_END || text_byte == CH_LF) ? n : 2'd0;
   end

   assign next_count = (byte_count_ff == COUNT_MAX) ? COUNT_MAX
                                                    : byte_count_ff + COUNT_WIDTH'(1);

   always_comb begin
      line_count_in     = line_count_ff;
      byte_count_in     = byte_count_ff;
      last_byte_in      = last_byte_ff;
      previous_byte_in  = previous_byte_ff;
      run_start_in      = run_start_ff;
      run_start_prev_in = run_start_prev_ff;
      first_tab_in      = first_tab_ff;
      tab_seen_in       = tab_seen_ff;
      if (accept) begin
         if (cmd == CMD_END || text_byte == CH_LF) begin
            if (cmd == CMD_END) begin
               line_count_in = LINE_W'(1);
            end else if (line_count_ff != LINE_MAX) begin
               line_count_in = line_count_ff + LINE_W'(1);
            end
            byte_count_in     = '0;
            last_byte_in      = '0;
            previous_byte_in  = '0;
            run_start_in      = '0;
            run_start_prev_in = '0;
            first_tab_in      = '0;
            tab_seen_in       = 1'b0;
         end else begin
            if (text_byte == CH_TAB && !tab_seen_ff) begin
               tab_seen_in  = 1'b1;
               first_tab_in = byte_count_ff;
            end
            run_start_prev_in = run_start_ff;
            if (text_byte != CH_SP && text_byte != CH_TAB) begin
               run_start_in = next_count;
            end
            previous_byte_in = last_byte_ff;
            last_byte_in     = text_byte;
            byte_count_in    = next_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff     <= LINE_W'(1);
         byte_count_ff     <= '0;
         last_byte_ff      <= '0;
         previous_byte_ff  <= '0;
         run_start_ff      <= '0;
         run_start_prev_ff <= '0;
         first_tab_ff      <= '0;
         tab_seen_ff       <= 1'b0;
      end else begin
         line_count_ff     <= line_count_in;
         byte_count_ff     <= byte_count_in;
         last_byte_ff      <= last_byte_in;
         previous_byte_ff  <= previous_byte_in;
         run_start_ff      <= run_start_in;
         run_start_prev_ff <= run_start_prev_in;
         first_tab_ff      <= first_tab_in;
         tab_seen_ff       <= tab_seen_in;
      end
   end

endmodule

`default_nettype wire

// File: src/tlsc_queue.sv
`default_nettype none

module tlsc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tlsc_pkg::burst_type burst,
   output logic                room,
   tlsc_rsp_if.source          rsp
);
   import tlsc_pkg::*;

   localparam int Q_W = $clog2(QUEUE_DEPTH + 1);

   result_type [QUEUE_DEPTH-1:0] q_ff, q_in;
   logic [Q_W-1:0]               count_ff, count_in;
   logic [Q_W-1:0]               base;
   logic                         pop;

   assign pop  = (count_ff != '0) && rsp.ready;
   assign base = count_ff - Q_W'(pop);
   // Space for a full burst even if nothing leaves this cycle.
   assign room = (count_ff <= Q_W'(QUEUE_DEPTH - MAX_RESULTS));

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
         q_in[i] = pop ? q_ff[i+1] : q_ff[i];
      end
      q_in[QUEUE_DEPTH-1] = q_ff[QUEUE_DEPTH-1];
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         for (int k = 0; k < MAX_RESULTS; k++) begin
            if (push && 2'(k) < burst.count && Q_W'(i) == base + Q_W'(k)) begin
               q_in[i] = burst.items[k];
            end
         end
      end
      count_in = base + (push ? Q_W'(burst.count) : Q_W'(0));
   end

   assign rsp.valid          = (count_ff != '0);
   assign rsp.violation_kind = q_ff[0].violation_kind;
   assign rsp.line_number    = q_ff[0].line_number;
   assign rsp.column_number  = q_ff[0].column_number;
   assign rsp.last_of_line   = q_ff[0].last_of_line;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

endmodule

`default_nettype wire

// File: src/text_line_style_checker.sv
// A line-closing word (LF or end of text) pushes its violations into the registered result queue.
// One word per cycle; a line queues up to three violations, drained one per cycle while rsp.ready.
// The input stalls only when the six-entry result queue lacks room for a full burst of three.
// Reset (synchronous, active high) clears configuration, empties the queue and restarts at line 1.
`default_nettype none

module text_line_style_checker (
   input  logic                            clock,
   input  logic                            reset,
   tlsc_req_if.sink                        req,
   tlsc_rsp_if.source                      rsp,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tlsc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [tlsc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [tlsc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import tlsc_pkg::*;

   cfg_type   cfg;
   burst_type burst;
   logic      room;
   logic      accept;

   // The input side is held back only by the result queue's fill level, which is
   // registered, so there is no combinational path from rsp.ready to req.ready.
   assign req.ready = room;
   assign accept    = req.valid && req.ready;

   // Configuration registers on the APB-style port. Writes land in the access cycle.
   tlsc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Per-line state lives in registers here. Each accepted word updates it, and
   // a line close evaluates the three checks in the same cycle and hands the
   // compacted burst of violations to the queue.
   tlsc_line u_line (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .cmd       (req.cmd),
      .text_byte (req.text_byte),
      .cfg       (cfg),
      .burst     (burst)
   );

   // Result queue: absorbs a burst of up to three violations per line and
   // presents the oldest one on rsp from a register.
   tlsc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (accept),
      .burst (burst),
      .room  (room),
      .rsp   (rsp)
   );

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;
   import tlsc_pkg::*;

   // Settle time after the last violation arrives before a register write or the
   // final verdict. It covers any work still in flight for lines with no result.
   localparam int unsigned SETTLE_CYCLES = 6;
   // A few hundred words in all, with bounded idle gaps on either side and up to
   // three violations per line, finish well inside this hard stop.
   localparam int unsigned CYCLE_LIMIT = 600000;
   // Register index past the end of the map; writes there must be ignored.
   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic       cmd;
      logic [7:0] text_byte;
   } text_word_type;

   logic clock;
   logic reset;

   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   tlsc_req_if req_ch ();
   tlsc_rsp_if rsp_ch ();

   text_line_style_checker dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Words waiting to be driven, and the violations the checker model says the
   // block owes us, oldest first.
   text_word_type words_to_send[$];
   result_type    violations_due[$];

   int unsigned words_queued;
   int unsigned mismatches;
   int unsigned cycle_count;

   // Driver and receiver pacing state. A nonzero calm count means the next that
   // many gaps are zero, which gives stretches of full-rate traffic.
   int unsigned   source_gap;
   int unsigned   source_calm;
   int unsigned   sink_stall;
   int unsigned   sink_calm;
   bit            word_taken;
   text_word_type next_word;
   result_type    want;
   result_type    got;

   // Checker model: configuration and the per-line tracking state.
   cfg_type                model_cfg;
   logic [LINE_W-1:0]      line_no;
   logic [COUNT_WIDTH-1:0] byte_cnt;
   logic [COUNT_WIDTH-1:0] run_start;
   logic [COUNT_WIDTH-1:0] run_start_prev;
   logic [COUNT_WIDTH-1:0] first_tab;
   logic [7:0]             last_ch;
   logic [7:0]             prev_ch;
   logic                   tab_found;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Pick the length of the next idle gap: mostly none or short, a few long.
   function automatic int unsigned pick_gap(inout int unsigned calm);
      int unsigned r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(99);
      if (r < 3) begin
         calm = $urandom_range(60, 20);
      end
      if (r < 55) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(3, 1);
      end
      return $urandom_range(40, 8);
   endfunction

   function void clear_line_state();
      byte_cnt       = '0;
      run_start      = '0;
      run_start_prev = '0;
      first_tab      = '0;
      last_ch        = '0;
      prev_ch        = '0;
      tab_found      = 1'b0;
   endfunction

   // One-based column of a zero-based index, held at the largest column.
   function automatic logic [COL_W-1:0] column_of(input logic [31:0] idx);
      logic [32:0] c;
      c = {1'b0, idx} + 33'd1;
      if (c > 33'(COL_MAX)) begin
         return COL_MAX;
      end
      return c[COL_W-1:0];
   endfunction

   // A line has just been closed: work out its violations in report order and
   // queue them, flagging the final one of the line.
   function void close_line_check();
      logic [COUNT_WIDTH-1:0] len;
      logic [COUNT_WIDTH-1:0] run;
      logic [7:0]             lastc;
      logic                   tab_hit;
      result_type             found [0:2];
      int                     n;
      len     = byte_cnt;
      run     = run_start;
      lastc   = last_ch;
      tab_hit = 1'b0;
      n       = 0;
      // A single trailing CR is not part of the line, so the checks look at the
      // state as it stood before that byte arrived.
      if (len != 0 && last_ch == CH_CR) begin
         len   = len - 1'b1;
         lastc = prev_ch;
         run   = run_start_prev;
      end
      if (model_cfg.max_line_length != 0 && 32'(len) > 32'(model_cfg.max_line_length)) begin
         found[n].violation_kind = KIND_LONG;
         found[n].column_number  = column_of(32'(model_cfg.max_line_length));
         n++;
      end
      if (model_cfg.tab_check_enable && tab_found) begin
         found[n].violation_kind = KIND_TAB;
         found[n].column_number  = column_of(32'(first_tab));
         tab_hit = 1'b1;
         n++;
      end
      // A trailing tab was already covered by the tab report when that fired.
      if (model_cfg.trailing_check_enable && len != 0 &&
          (lastc == CH_SP || (lastc == CH_TAB && !tab_hit))) begin
         found[n].violation_kind = KIND_TRAIL;
         found[n].column_number  = column_of(32'(run));
         n++;
      end
      for (int i = 0; i < n; i++) begin
         found[i].line_number  = line_no;
         found[i].last_of_line = (i == n - 1);
         violations_due.insert(violations_due.size(), found[i]);
      end
   endfunction

   // Advance the model by one accepted word.
   function void advance_checker(input logic cmd, input logic [7:0] b);
      logic [COUNT_WIDTH-1:0] next;
      if (cmd == CMD_END) begin
         // End of text closes the open line and numbering starts over.
         close_line_check();
         line_no = 1;
         clear_line_state();
      end else if (b == CH_LF) begin
         close_line_check();
         if (line_no != LINE_MAX) begin
            line_no = line_no + 1'b1;
         end
         clear_line_state();
      end else begin
         next = (byte_cnt == COUNT_MAX) ? byte_cnt : byte_cnt + 1'b1;
         if (b == CH_TAB && !tab_found) begin
            tab_found = 1'b1;
            first_tab = byte_cnt;
         end
         // The whitespace run start moves past every byte that is neither space
         // nor tab; the previous value is kept for the trailing CR case.
         run_start_prev = run_start;
         if (b != CH_SP && b != CH_TAB) begin
            run_start = next;
         end
         prev_ch  = last_ch;
         last_ch  = b;
         byte_cnt = next;
      end
   endfunction

   task automatic queue_word(input logic cmd, input logic [7:0] b);
      text_word_type w;
      w.cmd       = cmd;
      w.text_byte = b;
      words_to_send.insert(words_to_send.size(), w);
      words_queued++;
   endtask

   // One APB write: setup cycle, then access cycle until pready. The model's
   // copy of the register changes at the same point, with the same masking.
   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_MAX_LEN:  model_cfg.max_line_length       = value[15:0];
         REG_TAB_EN:   model_cfg.tab_check_enable      = value[0];
         REG_TRAIL_EN: model_cfg.trailing_check_enable = value[0];
         default: ;
      endcase
   endtask

   // Write all three registers. The unused upper data bits carry random junk,
   // which the block has to ignore.
   task automatic set_style(input logic [15:0] max_len, input logic tab_en,
                            input logic trail_en);
      logic [31:0] v;
      v = $urandom();
      v[15:0] = max_len;
      write_csr(REG_MAX_LEN, v);
      v = $urandom();
      v[0] = tab_en;
      write_csr(REG_TAB_EN, v);
      v = $urandom();
      v[0] = trail_en;
      write_csr(REG_TRAIL_EN, v);
   endtask

   // Wait until the driver has nothing left, every owed violation has come
   // back, and then the settle time for lines that produce no result.
   task automatic wait_quiet();
      do begin
         @(posedge clock);
      end while (!(words_to_send.size() == 0 && !req_ch.valid && violations_due.size() == 0));
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // A phase of random lines under one register setting. Most lines are well
   // formed with random content around the interesting boundaries; a few are
   // raw noise, unterminated, or cut short by end of text.
   task automatic random_phase(input logic [15:0] max_len, input logic tab_en,
                               input logic trail_en, input int unsigned n_words);
      int unsigned start;
      int unsigned len_cap;
      int unsigned len;
      int unsigned r;
      logic [7:0]  b;
      wait_quiet();
      set_style(max_len, tab_en, trail_en);
      start   = words_queued;
      len_cap = (max_len == 0 || max_len > 12) ? 12 : max_len + 3;
      while (words_queued - start < n_words) begin
         r = $urandom_range(99);
         if (r < 8) begin
            // Raw bytes, LF included.
            repeat ($urandom_range(12, 1)) queue_word(CMD_BYTE, 8'($urandom_range(255)));
         end else begin
            len = $urandom_range(len_cap);
            for (int i = 0; i < len; i++) begin
               r = $urandom_range(99);
               if (r < 50) begin
                  b = 8'($urandom_range(8'h7E, 8'h21));
               end else if (r < 65) begin
                  b = CH_SP;
               end else if (r < 75) begin
                  b = CH_TAB;
               end else if (r < 80) begin
                  b = CH_CR;
               end else begin
                  b = 8'($urandom_range(255));
                  if (b == CH_LF) begin
                     b = CH_CR;
                  end
               end
               queue_word(CMD_BYTE, b);
            end
            r = $urandom_range(99);
            if (r < 30) begin
               repeat ($urandom_range(3, 1)) begin
                  queue_word(CMD_BYTE, $urandom_range(1) ? CH_SP : CH_TAB);
               end
               if ($urandom_range(3) == 0) begin
                  queue_word(CMD_BYTE, CH_CR);
               end
            end else if (r < 45) begin
               queue_word(CMD_BYTE, CH_CR);
            end
            r = $urandom_range(99);
            if (r < 9) begin
               queue_word(CMD_END, 8'($urandom_range(255)));
            end else if (r >= 14) begin
               queue_word(CMD_BYTE, CH_LF);
            end
         end
      end
      // Close whatever line is open so no partial line spans a register change.
      queue_word(CMD_BYTE, CH_LF);
   endtask

   // Free-running cycle count with a hard stop.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Input driver. A word stays on the bus until it has been taken; after that
   // the driver idles for the gap drawn when the word went out.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_ch.valid && !word_taken) begin
            // Still waiting for ready; hold the word.
         end else begin
            word_taken = 1'b0;
            if (source_gap > 0) begin
               source_gap--;
               req_ch.valid <= 1'b0;
            end else if (words_to_send.size() > 0) begin
               next_word = words_to_send.pop_front();
               req_ch.valid     <= 1'b1;
               req_ch.cmd       <= next_word.cmd;
               req_ch.text_byte <= next_word.text_byte;
               source_gap = pick_gap(source_calm);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Every accepted word steps the model, which queues whatever it expects.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         advance_checker(req_ch.cmd, req_ch.text_byte);
         word_taken = 1'b1;
      end
   end

   // Result side back-pressure: ready drops for random stretches.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (sink_stall > 0) begin
         sink_stall--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         sink_stall = pick_gap(sink_calm);
      end
   end

   // Result monitor: each accepted violation is matched against the oldest one
   // the model produced.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.violation_kind = rsp_ch.violation_kind;
         got.line_number    = rsp_ch.line_number;
         got.column_number  = rsp_ch.column_number;
         got.last_of_line   = rsp_ch.last_of_line;
         if (violations_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected violation: kind %0d line %0d col %0d last %b",
                        got.violation_kind, got.line_number, got.column_number,
                        got.last_of_line);
            end
         end else begin
            want = violations_due.pop_front();
            if (got.violation_kind !== want.violation_kind ||
                got.line_number    !== want.line_number ||
                got.column_number  !== want.column_number ||
                got.last_of_line   !== want.last_of_line) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("violation mismatch: expected kind %0d line %0d col %0d last %b",
                           want.violation_kind, want.line_number, want.column_number,
                           want.last_of_line);
                  $display("                         got kind %0d line %0d col %0d last %b",
                           got.violation_kind, got.line_number, got.column_number,
                           got.last_of_line);
               end
            end
         end
      end
   end

   initial begin
      // Every block input gets a known value at time zero.
      reset            = 1'b1;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      req_ch.valid     = 1'b0;
      req_ch.cmd       = CMD_BYTE;
      req_ch.text_byte = '0;
      rsp_ch.ready     = 1'b0;
      words_queued     = 0;
      mismatches       = 0;
      cycle_count      = 0;
      source_gap       = 0;
      source_calm      = 0;
      sink_stall       = 0;
      sink_calm        = 0;
      word_taken       = 1'b0;
      model_cfg        = '0;
      line_no          = 1;
      clear_line_state();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. Short limit with both checks on; a write to the unused
      // register index must leave the setting alone.
      set_style(16'd3, 1'b1, 1'b1);
      write_csr(REG_UNUSED, '1);

      // Too long, tab, and a trailing space run: all three reports on one line.
      queue_word(CMD_BYTE, 8'h61);
      queue_word(CMD_BYTE, CH_TAB);
      queue_word(CMD_BYTE, 8'h62);
      queue_word(CMD_BYTE, CH_SP);
      queue_word(CMD_BYTE, CH_SP);
      queue_word(CMD_BYTE, CH_LF);
      // Trailing CR is dropped, so the length stays under the limit and the
      // trailing tab is left to the tab report.
      queue_word(CMD_BYTE, 8'h78);
      queue_word(CMD_BYTE, CH_TAB);
      queue_word(CMD_BYTE, CH_CR);
      queue_word(CMD_BYTE, CH_LF);
      // Empty line, then a line holding only a CR.
      queue_word(CMD_BYTE, CH_LF);
      queue_word(CMD_BYTE, CH_CR);
      queue_word(CMD_BYTE, CH_LF);
      // Extreme byte values, closed by end of text with a full byte alongside.
      queue_word(CMD_BYTE, 8'hFF);
      queue_word(CMD_BYTE, 8'h00);
      queue_word(CMD_END, 8'hFF);
      // End of text on an empty line, then a space-only line numbered from one.
      queue_word(CMD_END, 8'h00);
      queue_word(CMD_BYTE, CH_SP);
      queue_word(CMD_BYTE, CH_LF);

      // Random part, one phase per setting, with a full drain between phases.
      random_phase(16'd0, 1'b0, 1'b0, 40);
      random_phase(16'd8, 1'b1, 1'b1, 60);
      random_phase(16'd1, 1'b1, 1'b0, 40);
      random_phase(16'd5, 1'b0, 1'b1, 40);
      random_phase(16'hFFFF, 1'b1, 1'b1, 40);

      random_phase(16'($urandom_range(12, 2)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), 60);

      wait_quiet();
      if (violations_due.size() != 0) begin
         mismatches += violations_due.size();
         $display("%0d expected violations never arrived", violations_due.size());
      end
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
